[src/gsum_pkg.sv]
`default_nettype none
package gsum_pkg;

  localparam int NODES  = 4096;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = NODE_W + 1;
  localparam int LVL_W  = 16;
  localparam int PROD_W = LVL_W + CNT_W;
  localparam int OP_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_MERGE = 2'd0;
  localparam logic [OP_W-1:0] OP_SMALL = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_K  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE = 2'd1;

  localparam logic [LVL_W-1:0] SCALE_K_RESET  = 16'd6400;
  localparam logic [CNT_W-1:0] MIN_SIZE_RESET = 13'd20;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic clear;    // write reset values at the sweep address
    logic load;     // take the input item
    logic walk;     // follow one parent link
    logic root_a;   // first root found, compress, start the second find
    logic root_b;   // second root found, compress
    logic rd_b;     // read size and level of the second root
    logic cap_a;    // capture size and level of the first root
    logic cap_b;    // capture size and level of the second root
    logic mul_a;
    logic mul_b;
    logic merge;
    logic out_load;
  } gsum_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic clear_last;
    logic is_root;
    logic is_edge;
    logic is_thresh;
    logic same;
    logic merge_ok;
    logic out_busy;
  } gsum_sts_t;

endpackage
`default_nettype wire

[src/gsum_in_if.sv]
`default_nettype none
interface gsum_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] node_a;
  logic [11:0] node_b;
  logic [15:0] edge_weight;
  modport source(output valid, opcode, node_a, node_b, edge_weight, input ready);
  modport sink(input valid, opcode, node_a, node_b, edge_weight, output ready);
endinterface
`default_nettype wire

[src/gsum_out_if.sv]
`default_nettype none
interface gsum_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] root_label;
  logic        merged;
  logic [12:0] region_size;
  modport source(output valid, root_label, merged, region_size, input ready);
  modport sink(input valid, root_label, merged, region_size, output ready);
endinterface
`default_nettype wire

[src/gsum_cfg_if.sv]
`default_nettype none
interface gsum_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;
  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

[src/gsum_ram.sv]
`default_nettype none
module gsum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/gsum_ctrl.sv]
`default_nettype none
module gsum_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gsum_pkg::gsum_sts_t sts,
  output gsum_pkg::gsum_cmd_t     cmd
);
  import gsum_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_FA_ISS = 13'b0000000000100,
    S_FA_CHK = 13'b0000000001000,
    S_FB_ISS = 13'b0000000010000,
    S_FB_CHK = 13'b0000000100000,
    S_RD_A   = 13'b0000001000000,
    S_CAP_A  = 13'b0000010000000,
    S_CAP_B  = 13'b0000100000000,
    S_MUL_A  = 13'b0001000000000,
    S_MUL_B  = 13'b0010000000000,
    S_DECIDE = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FA_ISS;
        end
      end
      S_FA_ISS: state_next = S_FA_CHK;
      S_FA_CHK: begin
        if (sts.is_root) begin
          cmd.root_a = 1'b1;
          state_next = sts.is_edge ? S_FB_ISS : S_RD_A;
        end else begin
          cmd.walk   = 1'b1;
          state_next = S_FA_ISS;
        end
      end
      S_FB_ISS: state_next = S_FB_CHK;
      S_FB_CHK: begin
        if (sts.is_root) begin
          cmd.root_b = 1'b1;
          state_next = S_RD_A;
        end else begin
          cmd.walk   = 1'b1;
          state_next = S_FB_ISS;
        end
      end
      S_RD_A: state_next = S_CAP_A;
      S_CAP_A: begin
        cmd.cap_a = 1'b1;
        cmd.rd_b  = 1'b1;
        state_next = (!sts.is_edge || sts.same) ? S_DONE : S_CAP_B;
      end
      S_CAP_B: begin
        cmd.cap_b  = 1'b1;
        state_next = sts.is_thresh ? S_MUL_A : S_DECIDE;
      end
      S_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.merge  = sts.merge_ok;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule
`default_nettype wire

[src/gsum_datapath.sv]
`default_nettype none
module gsum_datapath #(
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire gsum_pkg::gsum_cmd_t                  cmd,
  output gsum_pkg::gsum_sts_t                       sts,
  input  wire logic [gsum_pkg::OP_W-1:0]            in_opcode,
  input  wire logic [gsum_pkg::NODE_W-1:0]          in_node_a,
  input  wire logic [gsum_pkg::NODE_W-1:0]          in_node_b,
  input  wire logic [gsum_pkg::LVL_W-1:0]           in_weight,
  input  wire logic                                 cfg_valid,
  input  wire logic [gsum_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gsum_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [gsum_pkg::NODE_W-1:0]          out_root,
  output logic                                      out_merged,
  output logic      [gsum_pkg::CNT_W-1:0]           out_size
);
  import gsum_pkg::*;

  localparam int W_USE = (WEIGHT_BITS < LVL_W) ? WEIGHT_BITS : LVL_W;
  localparam logic [LVL_W-1:0] WMASK = LVL_W'((33'd1 << W_USE) - 33'd1);

  logic [LVL_W-1:0]  scale_k;
  logic [CNT_W-1:0]  min_size;
  logic [OP_W-1:0]   op;
  logic [NODE_W-1:0] node_b, cur, start, ra, rb, clr_addr;
  logic [LVL_W-1:0]  w, la, lb;
  logic [CNT_W-1:0]  ca, cb;
  logic [PROD_W-1:0] prod;
  logic              ok_a;
  logic [NODE_W-1:0] res_root;
  logic [CNT_W-1:0]  res_size;
  logic              res_did;

  logic              p_we, c_we, l_we;
  logic [NODE_W-1:0] p_waddr, c_waddr, l_waddr, p_wdata, p_rdata, sz_raddr;
  logic [CNT_W-1:0]  c_wdata, c_rdata;
  logic [LVL_W:0]    l_wdata, l_rdata;

  logic              thresh, preset, ok_b, below_min;
  logic [NODE_W-1:0] winner, loser;
  logic [CNT_W-1:0]  sum;
  logic [LVL_W-1:0]  lmax, lnew, diff_a, diff_b;

  assign thresh    = (op == OP_MERGE);
  assign preset    = thresh && !l_rdata[LVL_W];
  assign lnew      = preset ? w : l_rdata[LVL_W-1:0];
  assign winner    = (ca > cb) ? ra : rb;
  assign loser     = (ca > cb) ? rb : ra;
  assign sum       = ca + cb;
  assign diff_a    = w - la;
  assign diff_b    = w - lb;
  assign ok_b      = (w <= lb) || (prod <= PROD_W'(scale_k));
  assign below_min = (ca < min_size) || (cb < min_size);
  assign sz_raddr  = cmd.rd_b ? rb : ra;

  always_comb begin
    lmax = (la > lb) ? la : lb;
    if (w > lmax) lmax = w;
  end

  assign sts.clear_last = (clr_addr == NODE_W'(NODES - 1));
  assign sts.is_root    = (p_rdata == cur);
  assign sts.is_edge    = (op == OP_MERGE) || (op == OP_SMALL);
  assign sts.is_thresh  = thresh;
  assign sts.same       = (ra == rb);
  assign sts.merge_ok   = thresh ? (ok_a && ok_b) : below_min;
  assign sts.out_busy   = out_valid && !out_ready;

  // Write port selection; the commands that write never coincide.
  always_comb begin
    p_we = 1'b0; p_waddr = start; p_wdata = cur;
    c_we = 1'b0; c_waddr = winner; c_wdata = sum;
    l_we = 1'b0; l_waddr = ra; l_wdata = {1'b1, w};
    priority if (cmd.clear) begin
      p_we = 1'b1; p_waddr = clr_addr; p_wdata = clr_addr;
      c_we = 1'b1; c_waddr = clr_addr; c_wdata = CNT_W'(1);
      l_we = 1'b1; l_waddr = clr_addr; l_wdata = '0;
    end else if (cmd.root_a || cmd.root_b) begin
      p_we = 1'b1;
    end else if (cmd.cap_a) begin
      l_we = preset && (ra != rb) && sts.is_edge;
    end else if (cmd.cap_b) begin
      l_we = preset; l_waddr = rb;
    end else if (cmd.merge) begin
      p_we = 1'b1; p_waddr = loser; p_wdata = winner;
      c_we = 1'b1;
      l_we = thresh; l_waddr = winner; l_wdata = {1'b1, lmax};
    end
  end

  gsum_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_parent (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(cur), .rdata(p_rdata)
  );
  gsum_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_count (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(sz_raddr), .rdata(c_rdata)
  );
  gsum_ram #(.WIDTH(LVL_W + 1), .DEPTH(NODES)) u_level (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(sz_raddr), .rdata(l_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_k   <= SCALE_K_RESET;
      min_size  <= MIN_SIZE_RESET;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SCALE_K:  scale_k  <= cfg_data;
          REG_MIN_SIZE: min_size <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      out_valid <= cmd.out_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= in_opcode;
      node_b <= in_node_b;
      w      <= in_weight & WMASK;
      cur    <= in_node_a;
      start  <= in_node_a;
    end
    if (cmd.walk) cur <= p_rdata;
    if (cmd.root_a) begin
      ra    <= cur;
      cur   <= node_b;
      start <= node_b;
    end
    if (cmd.root_b) rb <= cur;
    if (cmd.cap_a) begin
      ca       <= c_rdata;
      la       <= lnew;
      res_root <= ra;
      res_size <= c_rdata;
      res_did  <= 1'b0;
    end
    if (cmd.cap_b) begin
      cb <= c_rdata;
      lb <= lnew;
    end
    if (cmd.mul_a) prod <= PROD_W'(diff_a * ca);
    if (cmd.mul_b) begin
      ok_a <= (w <= la) || (prod <= PROD_W'(scale_k));
      prod <= PROD_W'(diff_b * cb);
    end
    if (cmd.merge) begin
      res_root <= winner;
      res_size <= sum;
      res_did  <= 1'b1;
    end
    if (cmd.out_load) begin
      out_root   <= res_root;
      out_size   <= res_size;
      out_merged <= res_did;
    end
  end
endmodule
`default_nettype wire

[src/graph_segment_union_merge.sv]
`default_nettype none
// Channel     Role    Payload
// item_in     sink    opcode, node_a, node_b, edge_weight
// result_out  source  root_label, merged, region_size
// cfg         sink    reg_index, wdata (0 scale_k, 1 min_size)
//
// After reset the node tables are swept (each node its own root of size one,
// no level); items wait then, configuration writes do not. Each find visits
// its nodes one by one, the root included. Beyond the finds a query or a
// same-region edge reads the first root, a small-region edge also reads the
// second and decides, and a threshold edge also runs the two multiplies.
// A stalled consumer holds only the final output load; one item at a time.
module graph_segment_union_merge #(
  parameter int WEIGHT_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  gsum_in_if.sink    item_in,
  gsum_out_if.source result_out,
  gsum_cfg_if.sink   cfg
);
  import gsum_pkg::*;

  gsum_cmd_t cmd;
  gsum_sts_t sts;

  // Configuration registers are always writable.
  assign cfg.ready = 1'b1;

  // The sequencer walks each find link by link, then reads the roots'
  // sizes and levels and, for an edge, decides the merge.
  gsum_ctrl u_ctrl (
    .clk,
    .rst,
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .sts,
    .cmd
  );

  // The datapath holds the node tables, the threshold multiplier, the
  // configuration registers and the output register.
  gsum_datapath #(.WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk,
    .rst,
    .cmd,
    .sts,
    .in_opcode  (item_in.opcode),
    .in_node_a  (item_in.node_a),
    .in_node_b  (item_in.node_b),
    .in_weight  (item_in.edge_weight),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.reg_index),
    .cfg_data   (cfg.wdata),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_root   (result_out.root_label),
    .out_merged (result_out.merged),
    .out_size   (result_out.region_size)
  );
endmodule
`default_nettype wire

[src/gsum_checker.sv]
`default_nettype none
module gsum_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_merged,
  input wire logic [12:0] out_size,
  input wire logic [11:0] out_root
);
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block not in clearing state after reset");

  a_merge_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_merged |-> out_size >= 13'd2)
    else $error("merged region smaller than two nodes");

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_size != 13'd0 && out_size <= 13'd4096)
    else $error("region size out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_root) && $stable(out_size))
    else $error("stalled result changed");
endmodule

bind graph_segment_union_merge gsum_checker u_gsum_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (item_in.ready),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .out_merged (result_out.merged),
  .out_size   (result_out.region_size),
  .out_root   (result_out.root_label)
);
`default_nettype wire
